/* rtl/bcg_pkg.sv */
// Shared types and constants for the bounding circle grower.
// Depends on nothing; imported by the multiplier, the restoring unit, the top level and the bench.
`default_nettype none
package bcg_pkg;

    localparam int CW        = 32;  // centre and point coordinate width
    localparam int RW        = 31;  // radius width
    localparam int CFG_IDX_W = 2;
    localparam int NUM_W     = 66;  // squared distance width
    localparam int ROOT_W    = 33;  // root and quotient width
    localparam int REM_W     = 36;  // partial remainder width
    localparam int ITER_N    = 33;  // steps per root or quotient
    localparam int CNT_W     = 6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEED_CX = 2'd0,
        CFG_SEED_CY = 2'd1,
        CFG_SEED_R  = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ITER_SQRT = 2'b01,
        ITER_DIV  = 2'b10
    } iter_mode_t;

    typedef struct packed {
        logic              start;
        iter_mode_t        mode;
        logic [REM_W-1:0]  rem;
        logic [NUM_W-1:0]  bits;
        logic [ROOT_W-1:0] divisor;
    } iter_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } iter_stat_t;

endpackage
`default_nettype wire

/* rtl/bcg_ifs.sv */
// Channel interfaces of the bounding circle grower: points in, circles out,
// and the seed configuration write channel. No dependencies.
`default_nettype none
interface bcg_pt_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic              first_point;
    modport source (output valid, point_x, point_y, first_point, input ready);
    modport sink   (input valid, point_x, point_y, first_point, output ready);
endinterface

interface bcg_res_if;
    logic              valid;
    logic              ready;
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic [30:0]        radius;
    logic              grew;
    modport source (output valid, centre_x, centre_y, radius, grew, input ready);
    modport sink   (input valid, centre_x, centre_y, radius, grew, output ready);
endinterface

interface bcg_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/bcg_mul.sv */
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on bcg_pkg.
`default_nettype none
module bcg_mul (
    input  wire logic                   clk,
    input  wire logic [bcg_pkg::CW-1:0] a,
    input  wire logic [bcg_pkg::CW-1:0] b,
    output logic [2*bcg_pkg::CW-1:0]    p
);
    import bcg_pkg::*;

    logic [2*CW-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;
endmodule
`default_nettype wire

/* rtl/bcg_iter.sv */
// Shared restoring unit: one trial subtraction per cycle, used for the
// integer square root (two bits a step) and for division (one bit a step).
// Depends on bcg_pkg.
`default_nettype none
module bcg_iter (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bcg_pkg::iter_cmd_t cmd,
    output bcg_pkg::iter_stat_t    stat,
    output logic [bcg_pkg::ROOT_W-1:0] result
);
    import bcg_pkg::*;

    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [NUM_W-1:0]  bits_reg, bits_next;
    logic [ROOT_W-1:0] acc_reg, acc_next;
    logic [ROOT_W-1:0] div_reg;
    iter_mode_t        mode_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [REM_W-1:0]  cand;
    logic [REM_W-1:0]  trial;
    logic              ge;

    always_comb
    begin
        if (mode_reg == ITER_SQRT)
        begin
            cand  = {rem_reg[REM_W-3:0], bits_reg[NUM_W-1 -: 2]};
            trial = {1'b0, acc_reg, 2'b01};
        end
        else
        begin
            cand  = {rem_reg[REM_W-2:0], bits_reg[NUM_W-1]};
            trial = {3'b000, div_reg};
        end
        ge = (cand >= trial);
    end

    always_comb
    begin
        rem_next  = rem_reg;
        bits_next = bits_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            rem_next  = cmd.rem;
            bits_next = cmd.bits;
            acc_next  = '0;
            cnt_next  = CNT_W'(ITER_N);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (cand - trial) : cand;
            acc_next = {acc_reg[ROOT_W-2:0], ge};
            if (mode_reg == ITER_SQRT)
                bits_next = {bits_reg[NUM_W-3:0], 2'b00};
            else
                bits_next = {bits_reg[NUM_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            mode_reg <= ITER_SQRT;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            if (cmd.start)
                mode_reg <= cmd.mode;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        bits_reg <= bits_next;
        acc_reg  <= acc_next;
        if (cmd.start)
            div_reg <= cmd.divisor;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = acc_reg;
endmodule
`default_nettype wire

/* rtl/bounding_circle_grow.sv */
// Top level of the bounding circle grower: sequencer, circle state, seed
// registers and output register. Depends on bcg_pkg, bcg_ifs, bcg_mul, bcg_iter.
//
//   channel | dir | words                               | accepted when
//   --------+-----+-------------------------------------+-------------------
//   pt      | in  | point_x, point_y, first_point       | pt.valid & pt.ready
//   res     | out | centre_x, centre_y, radius, grew    | res.valid & res.ready
//   cfg     | in  | index, data (seed x, seed y, radius)| cfg.valid & cfg.ready
//
// A point that stays inside the circle passes from acceptance through S_DIFF,
// S_SQX, S_SQY, S_RR and S_CMP to S_DONE, which writes the result register as
// the sequencer returns to S_IDLE for the next point. A point that grows the
// circle goes on through S_SQRT, S_HALF, S_MULX, S_NX, S_DIVX, S_MULY, S_NY
// and S_DIVY, with 33 steps on the shared restoring unit for the square root
// and for each of the two centre shift divisions, and with turns on the single
// shared 32x32 multiplier. The block takes one point at a time.
// Reset clears the circle, the seeds and all control state; no clearing pass.
// A result waiting in the output register does not stop the next point from
// being accepted; only the final write waits for the register to free up.
// The configuration channel is always ready.
`default_nettype none
module bounding_circle_grow (
    input  wire logic clk,
    input  wire logic rst_n,
    bcg_cfg_if.sink   cfg,
    bcg_pt_if.sink    pt,
    bcg_res_if.source res
);
    import bcg_pkg::*;

    // One-hot sequencer. The multiplier product issued in one state is
    // consumed in the following state.
    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_DIFF = 15'b000000000000010,
        S_SQX  = 15'b000000000000100,
        S_SQY  = 15'b000000000001000,
        S_RR   = 15'b000000000010000,
        S_CMP  = 15'b000000000100000,
        S_SQRT = 15'b000000001000000,
        S_HALF = 15'b000000010000000,
        S_MULX = 15'b000000100000000,
        S_NX   = 15'b000001000000000,
        S_DIVX = 15'b000010000000000,
        S_MULY = 15'b000100000000000,
        S_NY   = 15'b001000000000000,
        S_DIVY = 15'b010000000000000,
        S_DONE = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    // Seed registers, written by the configuration channel.
    logic [CW-1:0] seed_cx_reg, seed_cy_reg;
    logic [RW-1:0] seed_r_reg;

    // Circle state.
    logic [CW-1:0] cx_reg, cy_reg;
    logic [RW-1:0] r_reg;

    // Working registers of one point.
    logic [CW-1:0]     px_reg, py_reg;
    logic [CW-1:0]     ax_reg, ay_reg;
    logic              sgnx_reg, sgny_reg;
    logic [NUM_W-1:0]  sum_reg;
    logic [ROOT_W-1:0] dist_reg, half_reg, delta_reg;
    logic              grew_reg;

    // Output register.
    logic          out_valid_reg;
    logic [CW-1:0] out_cx_reg, out_cy_reg;
    logic [RW-1:0] out_r_reg;
    logic          out_grew_reg;

    logic [CW-1:0]     mul_a, mul_b;
    logic [2*CW-1:0]   prod;
    iter_cmd_t         icmd;
    iter_stat_t        istat;
    logic [ROOT_W-1:0] iresult;

    logic              pt_acc;
    logic              out_free;
    logic [CW:0]       dx, dy;
    logic [ROOT_W:0]   sum_rd;
    logic [ROOT_W-1:0] half_w;
    logic [2*CW:0]     numer;
    logic [CW-1:0]     ax_sel;
    logic [CW+2:0]     moved;
    logic [CW-1:0]     moved_sat;
    logic [CW-1:0]     c_sel;
    logic              sgn_sel;

    assign pt_acc   = pt.valid && pt.ready;
    assign out_free = !out_valid_reg || res.ready;
    assign pt.ready  = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    bcg_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    bcg_iter u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (icmd),
        .stat   (istat),
        .result (iresult)
    );

    // Multiplier operand selection.
    always_comb
    begin
        case (state_reg)
            S_SQX:
            begin
                mul_a = ax_reg;
                mul_b = ax_reg;
            end
            S_SQY:
            begin
                mul_a = ay_reg;
                mul_b = ay_reg;
            end
            S_RR:
            begin
                mul_a = {1'b0, r_reg};
                mul_b = {1'b0, r_reg};
            end
            S_MULX:
            begin
                mul_a = ax_reg;
                mul_b = delta_reg[CW-1:0];
            end
            S_MULY:
            begin
                mul_a = ay_reg;
                mul_b = delta_reg[CW-1:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Differences to the point, two's complement with one guard bit.
    assign dx = {px_reg[CW-1], px_reg} - {cx_reg[CW-1], cx_reg};
    assign dy = {py_reg[CW-1], py_reg} - {cy_reg[CW-1], cy_reg};

    // Radius growth: half of radius plus distance, and the step beyond it.
    assign sum_rd = {3'b000, r_reg} + {1'b0, dist_reg};
    assign half_w = sum_rd[ROOT_W:1];

    // Shift numerator |d| * delta; delta has one bit above the multiplier width.
    assign ax_sel = (state_reg == S_NX) ? ax_reg : ay_reg;
    assign numer  = {1'b0, prod} + (delta_reg[ROOT_W-1] ? {1'b0, ax_sel, {CW{1'b0}}} : '0);

    // Division command for the centre shift and the root command.
    always_comb
    begin
        icmd.start   = 1'b0;
        icmd.mode    = ITER_DIV;
        icmd.rem     = '0;
        icmd.bits    = '0;
        icmd.divisor = dist_reg;
        if ((state_reg == S_CMP) && (sum_reg > {2'b00, prod}))
        begin
            icmd.start = 1'b1;
            icmd.mode  = ITER_SQRT;
            icmd.bits  = sum_reg;
        end
        else if ((state_reg == S_NX) || (state_reg == S_NY))
        begin
            // The quotient never exceeds |d|, so the upper half of the
            // numerator is already below the divisor.
            icmd.start = 1'b1;
            icmd.rem   = {{(REM_W-(2*CW+1-ROOT_W)){1'b0}}, numer[2*CW:ROOT_W]};
            icmd.bits  = {numer[ROOT_W-1:0], {(NUM_W-ROOT_W){1'b0}}};
        end
    end

    // Centre move with clamping to the signed 32-bit range.
    assign c_sel   = (state_reg == S_DIVX) ? cx_reg : cy_reg;
    assign sgn_sel = (state_reg == S_DIVX) ? sgnx_reg : sgny_reg;
    assign moved   = sgn_sel
                   ? ({{3{c_sel[CW-1]}}, c_sel} - {2'b00, iresult})
                   : ({{3{c_sel[CW-1]}}, c_sel} + {2'b00, iresult});
    always_comb
    begin
        if (moved[CW+2:CW-1] == {4{moved[CW+2]}})
            moved_sat = moved[CW-1:0];
        else if (moved[CW+2])
            moved_sat = {1'b1, {(CW-1){1'b0}}};
        else
            moved_sat = {1'b0, {(CW-1){1'b1}}};
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (pt_acc) state_next = S_DIFF;
            S_DIFF: state_next = S_SQX;
            S_SQX:  state_next = S_SQY;
            S_SQY:  state_next = S_RR;
            S_RR:   state_next = S_CMP;
            S_CMP:  state_next = icmd.start ? S_SQRT : S_DONE;
            S_SQRT: if (istat.done) state_next = S_HALF;
            S_HALF: state_next = S_MULX;
            S_MULX: state_next = S_NX;
            S_NX:   state_next = S_DIVX;
            S_DIVX: if (istat.done) state_next = S_MULY;
            S_MULY: state_next = S_NY;
            S_NY:   state_next = S_DIVY;
            S_DIVY: if (istat.done) state_next = S_DONE;
            S_DONE: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seed_cx_reg   <= '0;
            seed_cy_reg   <= '0;
            seed_r_reg    <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            r_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_SEED_CX: seed_cx_reg <= cfg.data;
                    CFG_SEED_CY: seed_cy_reg <= cfg.data;
                    CFG_SEED_R:  seed_r_reg  <= cfg.data[RW-1:0];
                    default: ;
                endcase
            end

            // A first point restarts from the seed circle.
            if (pt_acc && pt.first_point)
            begin
                cx_reg <= seed_cx_reg;
                cy_reg <= seed_cy_reg;
                r_reg  <= seed_r_reg;
            end
            if ((state_reg == S_DIVX) && istat.done)
                cx_reg <= moved_sat;
            if ((state_reg == S_DIVY) && istat.done)
            begin
                cy_reg <= moved_sat;
                r_reg  <= (half_reg > ROOT_W'({RW{1'b1}})) ? {RW{1'b1}} : half_reg[RW-1:0];
            end

            if ((state_reg == S_DONE) && out_free)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers of one point and the output payload.
    always_ff @(posedge clk)
    begin
        if (pt_acc)
        begin
            px_reg <= pt.point_x;
            py_reg <= pt.point_y;
        end
        if (state_reg == S_DIFF)
        begin
            sgnx_reg <= dx[CW];
            sgny_reg <= dy[CW];
            ax_reg   <= dx[CW] ? ((~dx[CW-1:0]) + CW'(1)) : dx[CW-1:0];
            ay_reg   <= dy[CW] ? ((~dy[CW-1:0]) + CW'(1)) : dy[CW-1:0];
        end
        if (state_reg == S_SQY)
            sum_reg <= {2'b00, prod};
        if (state_reg == S_RR)
            sum_reg <= sum_reg + {2'b00, prod};
        if (state_reg == S_CMP)
            grew_reg <= icmd.start;
        if ((state_reg == S_SQRT) && istat.done)
            dist_reg <= iresult;
        if (state_reg == S_HALF)
        begin
            half_reg  <= half_w;
            delta_reg <= half_w - {2'b00, r_reg};
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            out_cx_reg   <= cx_reg;
            out_cy_reg   <= cy_reg;
            out_r_reg    <= r_reg;
            out_grew_reg <= grew_reg;
        end
    end

    assign res.valid    = out_valid_reg;
    assign res.centre_x = out_cx_reg;
    assign res.centre_y = out_cy_reg;
    assign res.radius   = out_r_reg;
    assign res.grew     = out_grew_reg;
endmodule
`default_nettype wire

/* rtl/bcg_chk.sv */
// Port-level checks on the bounding circle grower, bound to the top level.
// Depends on the top level's channel interfaces through the bind below.
`default_nettype none
module bcg_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        pt_valid,
    input wire logic        pt_ready,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic [30:0] res_radius,
    input wire logic [31:0] res_centre_x
);
    // A result word waits until it is taken.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result word dropped before it was taken");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_radius) && $stable(res_centre_x))
        else $error("result word changed while stalled");

    // One point at a time: accepting a point closes the input.
    a_one_point: assert property (@(posedge clk) disable iff (!rst_n)
        pt_valid && pt_ready |=> !pt_ready)
        else $error("second point accepted while one is in work");

    // A new result appears only after a busy stretch of the sequencer.
    a_res_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(!pt_ready))
        else $error("result appeared without a point in work");
endmodule

bind bounding_circle_grow bcg_chk u_bcg_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .pt_valid     (pt.valid),
    .pt_ready     (pt.ready),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .res_radius   (res.radius),
    .res_centre_x (res.centre_x)
);
`default_nettype wire

/* sim/bounding_circle_grow_tb.sv */
// Self-checking regression bench for the bounding circle grower.
// Depends on bcg_pkg, bcg_ifs and the bounding_circle_grow RTL.
`timescale 1ns / 100ps
`default_nettype none
module bounding_circle_grow_tb;
    import bcg_pkg::*;

    localparam int N_RANDOM   = 1850;
    localparam int STALL_MAX  = 11;
    localparam int WATCHDOG   = 20000;
    localparam int SETTLE     = 200;

    typedef struct {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [30:0]        r;
        logic               grew;
    } circle_t;

    // One row of the directed table. When has_want is set the row carries a
    // result read off by hand; the predictor is checked against it as well.
    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic               first;
        logic               has_want;
        circle_t            want;
    } pt_row_t;

    logic clk;
    logic rst_n;
    bcg_cfg_if cfg_ch ();
    bcg_pt_if  pt_ch ();
    bcg_res_if res_ch ();

    bounding_circle_grow DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch.sink),
        .pt    (pt_ch.sink),
        .res   (res_ch.source)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Predictor state: the seed registers and the live circle.
    logic signed [31:0] seed_cx, seed_cy;
    logic [30:0]        seed_r;
    logic signed [31:0] circ_cx, circ_cy;
    logic [30:0]        circ_r;

    circle_t circles_due[$];
    int      err_count = 0;
    int      idle_cycles = 0;
    bit      rx_calm;      // no receiver stalls in the last part of the run

    // Floor square root of a 66-bit value, bit by bit.
    function automatic logic [32:0] root66(input logic [65:0] v);
        logic [67:0] rem;
        logic [34:0] root;
        logic [67:0] trial;
        rem = '0;
        root = '0;
        for (int i = 32; i >= 0; i--)
        begin
            rem = (rem << 2) | 68'(v[2*i +: 2]);
            trial = (68'(root) << 2) | 68'd1;
            if (rem >= trial)
            begin
                rem = rem - trial;
                root = (root << 1) | 35'd1;
            end
            else
                root = root << 1;
        end
        return root[32:0];
    endfunction

    function automatic logic signed [31:0] shift_axis(input logic signed [31:0] c,
            input logic signed [32:0] d, input logic [33:0] delta, input logic [32:0] root_d);
        logic [32:0]        m;
        logic [66:0]        q;
        logic signed [68:0] n;
        m = d < 0 ? 33'(-d) : 33'(d);
        q = (67'(m) * 67'(delta)) / 67'(root_d);
        n = d < 0 ? 69'(c) - 69'(q) : 69'(c) + 69'(q);
        if (n > 69'sd2147483647) return 32'sh7fffffff;
        if (n < -69'sd2147483648) return 32'sh80000000;
        return n[31:0];
    endfunction

    // Grows the model circle by one point and returns the expected word.
    function automatic circle_t grow_circle(input logic signed [31:0] px,
            input logic signed [31:0] py, input logic first);
        logic signed [32:0] dx, dy;
        logic signed [65:0] dxw, dyw;
        logic [65:0]        d2;
        logic [32:0]        root_d;
        logic [33:0]        half;
        circle_t            o;
        if (first)
        begin
            circ_cx = seed_cx;
            circ_cy = seed_cy;
            circ_r  = seed_r;
        end
        dx = 33'(px) - 33'(circ_cx);
        dy = 33'(py) - 33'(circ_cy);
        dxw = dx;
        dyw = dy;
        d2 = (dxw * dxw) + (dyw * dyw);
        o.grew = 1'b0;
        if (d2 > 66'(circ_r) * 66'(circ_r))
        begin
            root_d = root66(d2);
            half = (34'(circ_r) + 34'(root_d)) >> 1;
            o.grew = 1'b1;
            // Delta is taken before saturation; the distance is nonzero here.
            circ_cx = shift_axis(circ_cx, dx, half - 34'(circ_r), root_d);
            circ_cy = shift_axis(circ_cy, dy, half - 34'(circ_r), root_d);
            circ_r = half > 34'h7fffffff ? 31'h7fffffff : half[30:0];
        end
        o.cx = circ_cx;
        o.cy = circ_cy;
        o.r  = circ_r;
        return o;
    endfunction

    task automatic write_seed(input cfg_idx_t idx, input logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_SEED_CX: seed_cx = value;
            CFG_SEED_CY: seed_cy = value;
            CFG_SEED_R:  seed_r  = value[30:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_seeds(input logic [31:0] x, input logic [31:0] y,
            input logic [30:0] r);
        write_seed(CFG_SEED_CX, x);
        write_seed(CFG_SEED_CY, y);
        write_seed(CFG_SEED_R, {1'b0, r});
    endtask

    // Waits for the result queue to drain, then lets a point that stays
    // inside finish as well before anything is reconfigured.
    task automatic drain;
        while (circles_due.size() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // Sends one point with an optional gap first; gap_pct sets the odds.
    task automatic send_point(input logic signed [31:0] px, input logic signed [31:0] py,
            input logic first, input int gap_pct);
        if ($urandom_range(99) < gap_pct)
            repeat ($urandom_range(STALL_MAX, 1)) @(posedge clk);
        pt_ch.valid       <= 1'b1;
        pt_ch.point_x     <= px;
        pt_ch.point_y     <= py;
        pt_ch.first_point <= first;
        @(posedge clk);
        while (!pt_ch.ready) @(posedge clk);
        circles_due.push_back(grow_circle(px, py, first));
        pt_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Random coordinate: half the time near the seed so the circle grows in steps,
    // otherwise anywhere in the full range or a non-negative value so every bit toggles.
    function automatic logic signed [31:0] pick_coord(input logic signed [31:0] near);
        case ($urandom_range(3))
            0: return $urandom;
            1: return near + $signed(32'($urandom_range(32'h00ffffff))) - 32'sh00800000;
            2: return near + $signed(32'($urandom_range(32'h000fffff))) - 32'sh00080000;
            default: return $signed(32'($urandom_range(32'h7fffffff))) >>> $urandom_range(20);
        endcase
    endfunction

    // Result side: random stalls, then compare against the oldest circle.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (circles_due.size() == 0)
                begin
                    $display("%0t: unexpected circle cx=%h cy=%h r=%h grew=%b", $time,
                             res_ch.centre_x, res_ch.centre_y, res_ch.radius, res_ch.grew);
                    err_count++;
                end
                else
                begin
                    circle_t w;
                    w = circles_due.pop_front();
                    if (res_ch.centre_x !== w.cx)
                    begin
                        $display("%0t: centre_x expected %h actual %h", $time, w.cx,
                                 res_ch.centre_x);
                        err_count++;
                    end
                    if (res_ch.centre_y !== w.cy)
                    begin
                        $display("%0t: centre_y expected %h actual %h", $time, w.cy,
                                 res_ch.centre_y);
                        err_count++;
                    end
                    if (res_ch.radius !== w.r)
                    begin
                        $display("%0t: radius expected %h actual %h", $time, w.r,
                                 res_ch.radius);
                        err_count++;
                    end
                    if (res_ch.grew !== w.grew)
                    begin
                        $display("%0t: grew expected %b actual %b", $time, w.grew,
                                 res_ch.grew);
                        err_count++;
                    end
                end
            end
        end
    end

    // Random receiver stall bursts, switched off near the end.
    int rx_hold;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b1;
            rx_hold      <= 0;
        end
        else if (rx_hold > 0)
        begin
            rx_hold      <= rx_hold - 1;
            res_ch.ready <= (rx_hold == 1);
        end
        else if (!rx_calm && $urandom_range(99) < 20)
        begin
            rx_hold      <= $urandom_range(STALL_MAX, 1);
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= 1'b1;
    end

    // Watchdog: counts cycles in which no word moves on any channel.
    always @(posedge clk)
    begin
        if ((pt_ch.valid && pt_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("bounding_circle_grow regression: fail");
            $finish;
        end
    end

    pt_row_t rows[$];

    function automatic pt_row_t mk(input logic signed [31:0] x, input logic signed [31:0] y,
            input logic f);
        pt_row_t t;
        t.px = x;
        t.py = y;
        t.first = f;
        t.has_want = 1'b0;
        t.want = '{default: '0};
        return t;
    endfunction

    function automatic pt_row_t mkw(input logic signed [31:0] x, input logic signed [31:0] y,
            input logic f, input logic signed [31:0] cx, input logic signed [31:0] cy,
            input logic [30:0] r, input logic g);
        pt_row_t t;
        t = mk(x, y, f);
        t.has_want = 1'b1;
        t.want = '{cx: cx, cy: cy, r: r, grew: g};
        return t;
    endfunction

    initial
    begin
        logic signed [31:0] near_x, near_y;
        circle_t            chk;
        rx_calm      = 1'b0;
        seed_cx = '0; seed_cy = '0; seed_r = '0;
        circ_cx = '0; circ_cy = '0; circ_r = '0;
        rst_n             = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_SEED_CX;
        cfg_ch.data       = '0;
        pt_ch.valid       = 1'b0;
        pt_ch.point_x     = '0;
        pt_ch.point_y     = '0;
        pt_ch.first_point = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, circle from reset: the origin stays inside a zero
        // circle; (2,0) grows it to radius 1 centred at (1,0).
        rows.push_back(mkw(32'sd0, 32'sd0, 1'b0, 32'sd0, 32'sd0, 31'd0, 1'b0));
        rows.push_back(mkw(32'sd2, 32'sd0, 1'b0, 32'sd1, 32'sd0, 31'd1, 1'b1));
        // Point on the circle stays inside.
        rows.push_back(mkw(32'sd2, 32'sd0, 1'b0, 32'sd1, 32'sd0, 31'd1, 1'b0));
        // Outside by a hair: floor of the root equals the radius, no change.
        rows.push_back(mkw(32'sd2, 32'sd1, 1'b0, 32'sd1, 32'sd0, 31'd1, 1'b1));
        // First flag reloads the zero seed.
        rows.push_back(mkw(32'sd0, 32'sd0, 1'b1, 32'sd0, 32'sd0, 31'd0, 1'b0));
        // Extremes: opposite corners overflow the radius.
        rows.push_back(mk(32'sh7fffffff, 32'sh7fffffff, 1'b0));
        rows.push_back(mk(32'sh80000000, 32'sh80000000, 1'b0));
        rows.push_back(mk(32'sh80000000, 32'sh7fffffff, 1'b0));
        rows.push_back(mk(32'sh7fffffff, 32'sh80000000, 1'b0));
        rows.push_back(mk(32'sh80000000, 32'sh80000000, 1'b1));
        rows.push_back(mk(32'sh7fffffff, 32'sh7fffffff, 1'b0));
        rows.push_back(mk(-32'sd65536, 32'sd65536, 1'b1));
        rows.push_back(mk(32'sd3 <<< 16, -32'sd4 <<< 16, 1'b0));
        rows.push_back(mk(32'sh55555555, 32'shaaaaaaaa, 1'b0));
        foreach (rows[i])
        begin
            send_point(rows[i].px, rows[i].py, rows[i].first, 0);
            if (rows[i].has_want)
            begin
                chk = circles_due[$];
                if ((chk.cx !== rows[i].want.cx) || (chk.cy !== rows[i].want.cy) ||
                    (chk.r !== rows[i].want.r) || (chk.grew !== rows[i].want.grew))
                begin
                    $display("%0t: table row %0d expected %h %h %h %b actual %h %h %h %b",
                             $time, i, rows[i].want.cx, rows[i].want.cy, rows[i].want.r,
                             rows[i].want.grew, chk.cx, chk.cy, chk.r, chk.grew);
                    err_count++;
                end
            end
        end
        drain();

        // Seeds at the extremes; first points reload them.
        load_seeds(32'h7fffffff, 32'h80000000, 31'h7fffffff);
        send_point(32'sh80000000, 32'sh7fffffff, 1'b1, 0);
        send_point(32'sd0, 32'sd0, 1'b1, 0);
        drain();
        load_seeds(32'h80000000, 32'h7fffffff, 31'd0);
        send_point(32'sh7fffffff, 32'sh80000000, 1'b1, 0);
        send_point(32'sh80000000, 32'sh7fffffff, 1'b1, 0);
        send_point(32'sd1, -32'sd1, 1'b0, 0);
        drain();

        // Random phases, each with its own seed circle; most points follow a
        // fresh first point and often lie near the seed so the circle grows in steps.
        for (int ph = 0; ph < 8; ph++)
        begin
            load_seeds($urandom >>> $urandom_range(31), $urandom >>> $urandom_range(31),
                       31'($urandom) >> $urandom_range(31));
            near_x = seed_cx;
            near_y = seed_cy;
            for (int k = 0; k < N_RANDOM / 8; k++)
            begin
                if (ph == 7 && k > N_RANDOM / 16) rx_calm = 1'b1;
                if (ph == 3 && k == 100) drain();   // sender holds until all have come
                send_point(pick_coord(near_x), pick_coord(near_y),
                           $urandom_range(19) == 0,
                           rx_calm ? 0 : ($urandom_range(3) == 0 ? 0 : 25));
            end
            drain();
        end

        while (circles_due.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (err_count == 0)
            $display("bounding_circle_grow regression: pass");
        else
            $display("bounding_circle_grow regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
rtl/bcg_pkg.sv
rtl/bcg_ifs.sv
rtl/bcg_mul.sv
rtl/bcg_iter.sv
rtl/bounding_circle_grow.sv
rtl/bcg_chk.sv
sim/bounding_circle_grow_tb.sv
